/* src/per_flow_rate_limiter_assert.svh */
// assertion macros used by the checker file
// needs clk and rst_n in the scope where a macro is used
`ifndef PER_FLOW_RATE_LIMITER_ASSERT_SVH
`define PER_FLOW_RATE_LIMITER_ASSERT_SVH

// clocked check, off while reset is low
`define PFRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define PFRL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pfrl_pkg.sv */
// shared types and constants of the per-flow rate limiter
// no dependencies
`timescale 1ns / 1ps

package pfrl_pkg;

  localparam int FLOW_SLOTS     = 1024;
  localparam int WINDOW_SECONDS = 60;
  localparam int ADDR_W         = $clog2(FLOW_SLOTS);
  localparam int IDX_W          = 10;
  localparam int SIXTIETHS      = 60;
  localparam int MS_PER_SEC     = 1000;
  localparam int RECIP_SHIFT    = 22;
  localparam int RECIP60        = 69905;  // floor(2^22 / 60)
  localparam int DIV_STEPS      = 16;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);
  localparam int IN_DATA_W      = 80;
  localparam int OUT_DATA_W     = 48;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [15:0] DEF_LIMIT_RST = 16'd60;
  localparam logic        STRATEGY_RST  = 1'b1;
  localparam logic [7:0]  VIOL_THR_RST  = 8'd5;

  typedef enum logic [2:0] {
    MODE_CONSUME = 3'd0,
    MODE_QUERY   = 3'd1,
    MODE_ADD     = 3'd2,
    MODE_UPDATE  = 3'd3,
    MODE_BLOCK   = 3'd4,
    MODE_UNBLOCK = 3'd5,
    MODE_DELETE  = 3'd6
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_LIMIT = 2'd0,
    CFG_STRATEGY      = 2'd1,
    CFG_VIOL_THR      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        valid;
    logic        active;
    logic        bucket;
    logic [7:0]  viol;
    logic [15:0] limit;
    logic [21:0] level;
    logic [31:0] last;
    logic [31:0] wstart;
    logic [15:0] wcount;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_RD, ST_LD, ST_MUL, ST_UPD, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic clr;
    logic cap_in;
    logic ld;
    logic mul;
    logic upd;
    logic div_init;
    logic div_step;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } stat_t;

endpackage

/* src/pfrl_ram.sv */
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pfrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/pfrl_ctrl.sv */
// controller state machine of the rate limiter
// depends on pfrl_pkg
`timescale 1ns / 1ps

module pfrl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  pfrl_pkg::stat_t st,
  output pfrl_pkg::cmd_t  cmd
);
  import pfrl_pkg::*;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = ST_RD;
        end
      end
      ST_RD: state_nxt = ST_LD;
      ST_LD: begin
        cmd.ld    = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        // first cycle sets up the divider from the written-back record
        if (cnt_r == '0) cmd.div_init = 1'b1;
        else cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS)) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
    ovalid_nxt = cmd.out_ld ? 1'b1 : (out_tready ? 1'b0 : ovalid_r);
  end

  assign out_tvalid = ovalid_r;

endmodule

/* src/pfrl_dp.sv */
// datapath of the rate limiter: config registers, flow table, arithmetic
// depends on pfrl_pkg and pfrl_ram
`timescale 1ns / 1ps

module pfrl_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pfrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfrl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [2:0]                     in_mode,
  input  logic [pfrl_pkg::IN_DATA_W-1:0]  in_data,
  output logic [pfrl_pkg::OUT_DATA_W-1:0] out_data,
  input  pfrl_pkg::cmd_t                  cmd,
  output pfrl_pkg::stat_t                 st
);
  import pfrl_pkg::*;

  // config
  logic [15:0] def_limit_r;
  logic        strategy_r;
  logic [7:0]  viol_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_limit_r <= DEF_LIMIT_RST;
      strategy_r  <= STRATEGY_RST;
      viol_thr_r  <= VIOL_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEFAULT_LIMIT: def_limit_r <= cfg_wdata[15:0];
        CFG_STRATEGY:      strategy_r  <= cfg_wdata[0];
        CFG_VIOL_THR:      viol_thr_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [2:0]       mode_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      now_r;
  logic [15:0]      nl_r;
  logic [21:0]      add_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      mode_r <= in_mode;
      idx_r  <= in_data[9:0];
      now_r  <= in_data[41:10];
      nl_r   <= in_data[57:42];
      add_r  <= in_data[79:58];
    end
  end

  logic in_range;
  logic is_consume;
  assign in_range   = (32'(idx_r) < 32'(FLOW_SLOTS));
  assign is_consume = (mode_r == MODE_CONSUME);

  // clearing pass address
  logic [ADDR_W-1:0] clr_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr) clr_addr_r <= clr_addr_r + 1'b1;
  end
  assign st.clr_last = (clr_addr_r == ADDR_W'(FLOW_SLOTS - 1));

  // flow table
  rec_t              rd_rec, n_nxt, n_r, wr_rec;
  logic              ram_we;
  logic [ADDR_W-1:0] waddr;

  assign ram_we = cmd.clr || (cmd.upd && in_range);
  assign waddr  = cmd.clr ? clr_addr_r : ADDR_W'(idx_r);
  assign wr_rec = cmd.clr ? rec_t'('0) : n_nxt;

  pfrl_ram #(.WIDTH(REC_W), .DEPTH(FLOW_SLOTS)) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wr_rec),
    .raddr (ADDR_W'(idx_r)),
    .rdata (rd_rec)
  );

  // load with creation on first consume
  rec_t rc_r, rc_nxt;
  always_comb begin
    rc_nxt = rd_rec;
    if (is_consume && in_range && !rd_rec.valid) begin
      rc_nxt.valid  = 1'b1;
      rc_nxt.active = 1'b1;
      rc_nxt.bucket = strategy_r;
      rc_nxt.viol   = '0;
      rc_nxt.limit  = def_limit_r;
      rc_nxt.level  = 22'(def_limit_r * 22'(SIXTIETHS));
      rc_nxt.last   = now_r;
      rc_nxt.wstart = now_r;
      rc_nxt.wcount = '0;
    end
  end
  always_ff @(posedge clk) if (cmd.ld) rc_r <= rc_nxt;

  // refill product, cap, window expiry
  logic [47:0] prod_r;
  logic [21:0] cap_r;
  logic        wexp_r;
  logic [15:0] lim_eff;
  assign lim_eff = (mode_r == MODE_UPDATE) ? nl_r : rc_r.limit;
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      // elapsed time wraps at 32 bits
      prod_r <= 32'(now_r - rc_r.last) * lim_eff;
      cap_r  <= 22'(rc_r.limit * 22'(SIXTIETHS));
      wexp_r <= ((now_r - rc_r.wstart) >= 32'(WINDOW_SECONDS));
    end
  end

  // state update
  logic [48:0] refill_sum, est_sum;
  logic [21:0] refill;
  logic [22:0] add_sum;
  logic [21:0] add_clip;
  logic [7:0]  viol_inc;
  logic [15:0] wc0;
  logic        present, adm, allowed_nxt;

  always_comb begin
    refill_sum = 49'(rc_r.level) + 49'(prod_r);
    refill     = (refill_sum > 49'(cap_r)) ? cap_r : refill_sum[21:0];
    add_sum    = 23'(rc_r.level) + 23'(add_r);
    add_clip   = (add_sum > 23'(cap_r)) ? cap_r : add_sum[21:0];
    viol_inc   = (rc_r.viol == 8'hFF) ? rc_r.viol : rc_r.viol + 8'd1;
    wc0        = wexp_r ? 16'd0 : rc_r.wcount;
    n_nxt      = rc_r;
    adm        = 1'b0;
    if (is_consume) begin
      if (!rc_r.active || rc_r.viol >= viol_thr_r) begin
        adm = 1'b0;
      end else if (rc_r.bucket) begin
        n_nxt.last = now_r;
        if (refill >= 22'(SIXTIETHS)) begin
          n_nxt.level = refill - 22'(SIXTIETHS);
          adm         = 1'b1;
        end else begin
          n_nxt.level = refill;
          n_nxt.viol  = viol_inc;
        end
      end else begin
        if (wexp_r) n_nxt.wstart = now_r;
        if (wc0 < rc_r.limit) begin
          n_nxt.wcount = wc0 + 16'd1;
          adm          = 1'b1;
        end else begin
          n_nxt.wcount = wc0;
          n_nxt.viol   = viol_inc;
        end
      end
    end else if (rc_r.valid) begin
      unique case (mode_r)
        MODE_ADD:     n_nxt.level = add_clip;
        MODE_UPDATE:  n_nxt.limit = nl_r;
        MODE_BLOCK:   n_nxt.active = 1'b0;
        MODE_UNBLOCK: begin
          n_nxt.active = 1'b1;
          n_nxt.viol   = '0;
        end
        MODE_DELETE:  n_nxt.valid = 1'b0;
        default: ;
      endcase
    end
    present = n_nxt.valid && in_range;
    est_sum = 49'(n_nxt.level) + 49'(prod_r);
    if (!present)        allowed_nxt = 1'b1;
    else if (is_consume) allowed_nxt = adm;
    else if (n_nxt.bucket) allowed_nxt = (est_sum >= 49'(SIXTIETHS));
    else allowed_nxt = wexp_r || (n_nxt.wcount < n_nxt.limit);
  end

  logic present_r, allowed_r;
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      n_r       <= n_nxt;
      present_r <= present;
      allowed_r <= allowed_nxt;
    end
  end

  // wait time divider and whole-token estimate
  logic [16:0] q0_r;
  logic [15:0] quot_r;
  logic [16:0] drem_r, rem_sh;
  logic        low_lvl;
  assign low_lvl = (n_r.level < 22'(SIXTIETHS));
  assign rem_sh  = {drem_r[15:0], quot_r[15]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      q0_r   <= 17'((39'(n_r.level) * 39'(RECIP60)) >> RECIP_SHIFT);
      quot_r <= 16'(6'(22'(SIXTIETHS) - n_r.level) * 16'(MS_PER_SEC));
      drem_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, n_r.limit}) begin
        drem_r <= rem_sh - {1'b0, n_r.limit};
        quot_r <= {quot_r[14:0], 1'b1};
      end else begin
        drem_r <= rem_sh;
        quot_r <= {quot_r[14:0], 1'b0};
      end
    end
  end

  // result register
  logic [21:0] q_res;
  logic [16:0] q_fix;
  logic [15:0] rem_o, wait_o, win_rem;
  always_comb begin
    q_res   = n_r.level - 22'(q0_r * 17'(SIXTIETHS));
    q_fix   = (q_res >= 22'(SIXTIETHS)) ? q0_r + 17'd1 : q0_r;
    win_rem = (n_r.wcount < n_r.limit) ? n_r.limit - n_r.wcount : 16'd0;
    if (!present_r) begin
      rem_o  = def_limit_r;
      wait_o = '0;
    end else if (n_r.bucket) begin
      rem_o = q_fix[16] ? 16'hFFFF : q_fix[15:0];
      if (!low_lvl)              wait_o = '0;
      else if (n_r.limit == '0)  wait_o = 16'hFFFF;
      else                       wait_o = quot_r;
    end else begin
      rem_o  = win_rem;
      wait_o = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data <= {6'd0,
                   present_r ? n_r.viol : 8'd0,
                   present_r && !n_r.active,
                   wait_o, rem_o, allowed_r};
    end
  end

endmodule

/* src/per_flow_rate_limiter.sv */
// per-flow rate limiter: 1024-flow token bucket / fixed window table
// depends on pfrl_pkg, pfrl_ctrl, pfrl_dp, pfrl_ram
// processing: read, load, multiply, update and write-back, divider setup,
//   16 divider steps, result load; the load waits while a result is stalled
// one item at a time: in_tready stays low until the result has been loaded
// reset: synchronous active low; afterwards a clearing pass over every entry of
//   the flow table runs with in_tready low, config writes are taken throughout
`timescale 1ns / 1ps

module per_flow_rate_limiter (
  input  logic                           clk,
  input  logic                           rst_n,
  // config write port
  input  logic                           cfg_we,
  input  logic [pfrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfrl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pfrl_pkg::IN_DATA_W-1:0]  in_tdata,  // flow_index, now_sec, new_limit, added_sixtieths
  input  logic [2:0]                     in_tuser,  // mode
  // result items
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pfrl_pkg::OUT_DATA_W-1:0] out_tdata  // allowed, remaining, wait_ms, is_blocked, violations, pad
);
  import pfrl_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t st;

  // sequencer: clear pass, one item at a time through the table and divider
  pfrl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  // table read-modify-write, refill math and result formatting
  pfrl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_mode   (in_tuser),
    .in_data   (in_tdata),
    .out_data  (out_tdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

/* src/pfrl_checker.sv */
// port-level checks for the rate limiter, bound to the top level
// depends on per_flow_rate_limiter_assert.svh
`timescale 1ns / 1ps
`include "per_flow_rate_limiter_assert.svh"

module pfrl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // clearing pass holds off input right after reset
  `PFRL_ASSERT_RST(a_clr_after_rst, !rst_n |=> !in_tready, "input ready during clear pass")
  // one item at a time
  `PFRL_ASSERT(a_one_item, in_tvalid && in_tready |=> !in_tready, "second item taken early")
  // pad bits of the result stay zero
  `PFRL_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[47:42] == 6'd0, "result pad bits set")
  // stalled result holds
  `PFRL_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata),
    "stalled result changed")

endmodule

bind per_flow_rate_limiter pfrl_checker u_chk (.*);

/* tb/sv/tb.sv */
// self-checking testbench for per_flow_rate_limiter: directed table, then random phases
// depends on pfrl_pkg and the per_flow_rate_limiter rtl
`timescale 1ns / 1ps

module tb;
  import pfrl_pkg::*;

  localparam int STALL_LIMIT = 6000;  // idle cycles without any accept before giving up
  localparam int DRAIN_WAIT  = 60;    // margin over the block's latency from input accept to result valid
  localparam int LONG_HOLD   = 400;   // receiver hold-off used to back the block up

  // one result item
  typedef struct packed {
    logic        allowed;
    logic [15:0] remaining;
    logic [15:0] wait_ms;
    logic        is_blocked;
    logic [7:0]  violations;
  } verdict_t;

  // one row of the directed table
  typedef struct {
    logic [2:0]  mode;
    logic [9:0]  flow;
    logic [31:0] now;
    logic [15:0] nl;
    logic [21:0] add;
    bit          typed;
    verdict_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;  // flow_index, now_sec, new_limit, added_sixtieths
  logic [2:0] in_tuser = '0;            // mode
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;     // allowed, remaining, wait_ms, is_blocked, violations, pad

  always #1 clk = ~clk;

  per_flow_rate_limiter u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // shadow of the flow table and the registers
  logic [15:0] sh_def_limit;
  logic        sh_strategy;
  logic [7:0]  sh_threshold;
  bit          fl_valid  [FLOW_SLOTS];
  bit          fl_active [FLOW_SLOTS];
  bit          fl_bucket [FLOW_SLOTS];
  logic [7:0]  fl_viol   [FLOW_SLOTS];
  logic [15:0] fl_limit  [FLOW_SLOTS];
  logic [31:0] fl_level  [FLOW_SLOTS];
  logic [31:0] fl_last   [FLOW_SLOTS];
  logic [31:0] fl_wstart [FLOW_SLOTS];
  logic [15:0] fl_wcount [FLOW_SLOTS];

  verdict_t pending_verdicts[$];
  int  mismatches = 0;
  bit  idle_on = 1'b1;
  bit  long_hold = 1'b0;
  logic [31:0] clock_now = '0;

  // admission decision a query would make, no state change
  function automatic bit admits(int s, logic [31:0] now);
    logic [63:0] est;
    if (fl_bucket[s]) begin
      est = 64'(fl_level[s]) + 64'(32'(now - fl_last[s])) * 64'(fl_limit[s]);
      return est >= 64'(SIXTIETHS);
    end
    if (32'(now - fl_wstart[s]) >= 32'(WINDOW_SECONDS)) return 1'b1;
    return fl_wcount[s] < fl_limit[s];
  endfunction

  // cap the bucket level at limit * 60
  function automatic void clip(int s, logic [63:0] lvl);
    logic [63:0] cap;
    cap = 64'(fl_limit[s]) * 64'(SIXTIETHS);
    fl_level[s] = (lvl > cap) ? cap[31:0] : lvl[31:0];
  endfunction

  function automatic void bump_viol(int s);
    if (fl_viol[s] != 8'hFF) fl_viol[s] = fl_viol[s] + 8'd1;
  endfunction

  // rate limiter step: updates the shadow table and returns the result item
  function automatic verdict_t limiter_step(logic [2:0] mode, logic [9:0] flow,
                                            logic [31:0] now, logic [15:0] nl,
                                            logic [21:0] add);
    verdict_t v;
    int s;
    int adm;
    logic [31:0] w;
    s = int'(flow);
    adm = -1;
    if (mode == MODE_CONSUME) begin
      if (!fl_valid[s]) begin
        fl_valid[s] = 1; fl_active[s] = 1; fl_bucket[s] = sh_strategy;
        fl_viol[s] = '0; fl_limit[s] = sh_def_limit;
        fl_level[s] = 32'(sh_def_limit) * 32'(SIXTIETHS);
        fl_last[s] = now; fl_wstart[s] = now; fl_wcount[s] = '0;
      end
      if (!fl_active[s] || fl_viol[s] >= sh_threshold) begin
        adm = 0;  // refused outright, nothing counted
      end else if (fl_bucket[s]) begin
        clip(s, 64'(fl_level[s]) + 64'(32'(now - fl_last[s])) * 64'(fl_limit[s]));
        fl_last[s] = now;
        if (fl_level[s] >= 32'(SIXTIETHS)) begin
          fl_level[s] = fl_level[s] - 32'(SIXTIETHS);
          adm = 1;
        end else begin
          bump_viol(s);
          adm = 0;
        end
      end else begin
        if (32'(now - fl_wstart[s]) >= 32'(WINDOW_SECONDS)) begin
          fl_wstart[s] = now;
          fl_wcount[s] = '0;
        end
        if (fl_wcount[s] < fl_limit[s]) begin
          fl_wcount[s] = fl_wcount[s] + 16'd1;
          adm = 1;
        end else begin
          bump_viol(s);
          adm = 0;
        end
      end
    end else if (fl_valid[s]) begin
      case (mode)
        MODE_ADD:     clip(s, 64'(fl_level[s]) + 64'(add));
        MODE_UPDATE:  fl_limit[s] = nl;
        MODE_BLOCK:   fl_active[s] = 0;
        MODE_UNBLOCK: begin
          fl_active[s] = 1;
          fl_viol[s] = '0;
        end
        MODE_DELETE:  fl_valid[s] = 0;
        default: ;
      endcase
    end
    if (!fl_valid[s]) begin
      // absent flow report
      v = '{1'b1, sh_def_limit, 16'd0, 1'b0, 8'd0};
      return v;
    end
    v.allowed = (adm >= 0) ? adm[0] : admits(s, now);
    if (fl_bucket[s]) begin
      w = fl_level[s] / 32'(SIXTIETHS);
      v.remaining = (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
      if (fl_level[s] >= 32'(SIXTIETHS)) v.wait_ms = '0;
      else if (fl_limit[s] == 0) v.wait_ms = 16'hFFFF;
      else begin
        w = (32'(SIXTIETHS) - fl_level[s]) * 32'(MS_PER_SEC) / 32'(fl_limit[s]);
        v.wait_ms = (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
      end
    end else begin
      v.remaining = (fl_wcount[s] < fl_limit[s]) ? fl_limit[s] - fl_wcount[s] : 16'd0;
      v.wait_ms = '0;
    end
    v.is_blocked = !fl_active[s];
    v.violations = fl_viol[s];
    return v;
  endfunction

  // offer one item, optionally after a random gap, and wait for its accept
  task automatic send_item(logic [2:0] mode, logic [9:0] flow, logic [31:0] now,
                           logic [15:0] nl, logic [21:0] add, bit typed, verdict_t want);
    verdict_t v;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {add, nl, now, flow};
    do @(posedge clk); while (!in_tready);
    v = limiter_step(mode, flow, now, nl, add);
    pending_verdicts.push_back(typed ? want : v);
  endtask

  // let everything drain, then give the block its latency
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEFAULT_LIMIT: sh_def_limit = val;
      CFG_STRATEGY:      sh_strategy  = val[0];
      default:           sh_threshold = val[7:0];
    endcase
  endtask

  task automatic set_config(logic [15:0] lim, logic strat, logic [7:0] thr);
    write_reg(CFG_DEFAULT_LIMIT, lim);
    write_reg(CFG_STRATEGY, {15'd0, strat});
    write_reg(CFG_VIOL_THR, {8'd0, thr});
  endtask

  // random item, mostly aimed at a handful of flows with slowly moving time
  task automatic random_item;
    logic [2:0]  mode;
    logic [9:0]  flow;
    logic [15:0] nl;
    logic [21:0] add;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      mode = MODE_CONSUME;
    else if (pick < 62) mode = MODE_QUERY;
    else if (pick < 70) mode = MODE_ADD;
    else if (pick < 78) mode = MODE_UPDATE;
    else if (pick < 83) mode = MODE_BLOCK;
    else if (pick < 90) mode = MODE_UNBLOCK;
    else if (pick < 95) mode = MODE_DELETE;
    else                mode = 3'd7;  // unused code, behaves as a query
    flow = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 7)) : 10'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 85)      clock_now = clock_now + $urandom_range(0, 3);
    else if (pick < 97) clock_now = clock_now + $urandom_range(0, 120);
    else                clock_now = $urandom;  // may jump backwards
    nl  = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 10)) : 16'($urandom);
    add = $urandom_range(0, 1) ? 22'($urandom_range(0, 300)) : 22'($urandom);
    send_item(mode, flow, clock_now, nl, add, 1'b0, '0);
  endtask

  // directed rows, default registers after reset
  row_t directed[$] = '{
    // first consume creates a full bucket of 60 tokens and takes one
    '{MODE_CONSUME, 10'd0, 32'd0, 16'd0, 22'd0, 1, '{1'b1, 16'd59, 16'd0, 1'b0, 8'd0}},
    // query of an absent flow
    '{MODE_QUERY, 10'd5, 32'd0, 16'd0, 22'd0, 1, '{1'b1, 16'd60, 16'd0, 1'b0, 8'd0}},
    '{MODE_BLOCK, 10'd0, 32'd0, 16'd0, 22'd0, 1, '{1'b1, 16'd59, 16'd0, 1'b1, 8'd0}},
    // blocked flow is refused without a violation
    '{MODE_CONSUME, 10'd0, 32'd0, 16'd0, 22'd0, 1, '{1'b0, 16'd59, 16'd0, 1'b1, 8'd0}},
    '{MODE_UNBLOCK, 10'd0, 32'd0, 16'd0, 22'd0, 0, '0},
    // add the largest amount, clipped to the cap
    '{MODE_ADD, 10'd0, 32'd1, 16'd0, 22'h3FFFFF, 1, '{1'b1, 16'd60, 16'd0, 1'b0, 8'd0}},
    '{MODE_ADD, 10'd0, 32'd1, 16'd0, 22'd0, 0, '0},
    // zero limit: level kept, then drained, wait saturates
    '{MODE_UPDATE, 10'd0, 32'd1, 16'd0, 22'd0, 0, '0},
    '{MODE_CONSUME, 10'd0, 32'd2, 16'hFFFF, 22'h3FFFFF, 0, '0},
    '{MODE_CONSUME, 10'd0, 32'd2, 16'd0, 22'd0, 0, '0},
    '{MODE_QUERY, 10'd0, 32'd9, 16'd0, 22'd0, 0, '0},
    '{MODE_UPDATE, 10'd0, 32'd9, 16'hFFFF, 22'd0, 0, '0},
    '{MODE_ADD, 10'd0, 32'd9, 16'd0, 22'h3FFFFF, 0, '0},
    '{MODE_QUERY, 10'd0, 32'd9, 16'd0, 22'd0, 0, '0},
    '{MODE_DELETE, 10'd0, 32'd9, 16'd0, 22'd0, 1, '{1'b1, 16'd60, 16'd0, 1'b0, 8'd0}},
    '{3'd7, 10'd0, 32'd9, 16'd0, 22'd0, 1, '{1'b1, 16'd60, 16'd0, 1'b0, 8'd0}},
    // add, update, block, unblock and delete on an absent flow leave the table alone
    '{MODE_ADD, 10'd1023, 32'd9, 16'd0, 22'd5, 1, '{1'b1, 16'd60, 16'd0, 1'b0, 8'd0}},
    '{MODE_UPDATE, 10'd1023, 32'd9, 16'd7, 22'd0, 1, '{1'b1, 16'd60, 16'd0, 1'b0, 8'd0}},
    '{MODE_BLOCK, 10'd1023, 32'd9, 16'd0, 22'd0, 1, '{1'b1, 16'd60, 16'd0, 1'b0, 8'd0}},
    '{MODE_UNBLOCK, 10'd1023, 32'd9, 16'd0, 22'd0, 1, '{1'b1, 16'd60, 16'd0, 1'b0, 8'd0}},
    '{MODE_DELETE, 10'd1023, 32'd9, 16'd0, 22'd0, 1, '{1'b1, 16'd60, 16'd0, 1'b0, 8'd0}},
    // last slot at the top of time, then time going backwards
    '{MODE_CONSUME, 10'd1023, 32'hFFFFFFFF, 16'd0, 22'd0, 0, '0},
    '{MODE_CONSUME, 10'd1023, 32'hFFFFFFFF, 16'd0, 22'd0, 0, '0},
    '{MODE_CONSUME, 10'd1023, 32'd0, 16'd0, 22'd0, 0, '0}
  };

  // register settings walked by the random phases, extremes included
  logic [24:0] phase_cfg[8] = '{
    {16'd60, 1'b1, 8'd5}, {16'd3, 1'b0, 8'd2}, {16'hFFFF, 1'b1, 8'd255},
    {16'd0, 1'b1, 8'd0}, {16'd2, 1'b1, 8'd3}, {16'd5, 1'b0, 8'd255},
    {16'd0, 1'b0, 8'd1}, {16'hFFFF, 1'b0, 8'd5}
  };

  // stimulus
  initial begin
    sh_def_limit = DEF_LIMIT_RST;
    sh_strategy  = STRATEGY_RST;
    sh_threshold = VIOL_THR_RST;
    foreach (fl_valid[i]) fl_valid[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i])
      send_item(directed[i].mode, directed[i].flow, directed[i].now, directed[i].nl,
                directed[i].add, directed[i].typed, directed[i].want);
    drain();
    for (int p = 0; p < 8; p++) begin
      set_config(phase_cfg[p][24:9], phase_cfg[p][8], phase_cfg[p][7:0]);
      idle_on = (p < 7);  // the last phase runs back to back
      for (int n = 0; n < 215; n++) begin
        if (p == 1 && n == 20) long_hold = 1'b1;  // back the block up
        if (p == 3 && n == 100) begin
          // sender pause until every result is home
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (pending_verdicts.size() != 0) @(posedge clk);
        end
        random_item();
      end
      drain();
    end
    if (mismatches == 0) $display("PASS per_flow_rate_limiter");
    else $display("FAIL per_flow_rate_limiter");
    $finish;
  end

  // receiver: random stall bursts plus one long hold-off
  initial begin : receiver
    int stall_left;
    int held;
    stall_left = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        held++;
        if (held == LONG_HOLD) long_hold = 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checking and the no-progress watchdog
  int quiet_cycles = 0;
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL per_flow_rate_limiter");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[0], out_tdata[16:1], out_tdata[32:17], out_tdata[33],
                out_tdata[41:34]};
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", out_tdata);
        end else begin
          want = pending_verdicts.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp allowed=%0d rem=%0d wait=%0d blk=%0d viol=%0d,",
                        " got allowed=%0d rem=%0d wait=%0d blk=%0d viol=%0d"},
                       want.allowed, want.remaining, want.wait_ms, want.is_blocked,
                       want.violations, got.allowed, got.remaining, got.wait_ms,
                       got.is_blocked, got.violations);
          end
        end
      end
    end
  end

endmodule

/* files.f */
+incdir+src
src/pfrl_pkg.sv
src/pfrl_ram.sv
src/pfrl_ctrl.sv
src/pfrl_dp.sv
src/per_flow_rate_limiter.sv
src/pfrl_checker.sv
tb/sv/tb.sv
